/* src/deadband_cascaded_lowpass_core_macros.svh */
`ifndef DEADBAND_CASCADED_LOWPASS_CORE_MACROS_SVH
`define DEADBAND_CASCADED_LOWPASS_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define DCLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define DCLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, active through reset.
`define DCLP_ASSERT_RST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dclp_pkg.sv */
package dclp_pkg;

    localparam int JOINTS_DEF = 16;
    localparam int STAGES_DEF = 3;

    localparam int ANGLE_W    = 24;
    localparam int JOINT_W    = 4;
    localparam int DB_W       = 23;
    localparam int ALPHA_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam int Q_DEPTH    = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_REARM  = 1'b1;

    typedef struct packed {
        logic                       rearm;
        logic [JOINT_W-1:0]         joint;
        logic signed [ANGLE_W-1:0]  target;
        logic signed [ANGLE_W-1:0]  seed;
    } t_req;

    typedef struct packed {
        logic               filter_on;
        logic [DB_W-1:0]    deadband;
        logic [ALPHA_W-1:0] alpha;
    } t_cfg;

endpackage

/* src/dclp_ram.sv */
module dclp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/dclp_front.sv */
module dclp_front #(
    parameter int JOINTS = dclp_pkg::JOINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [dclp_pkg::JOINT_W-1:0]        i_joint,
    input  logic signed [dclp_pkg::ANGLE_W-1:0] i_target,
    input  logic signed [dclp_pkg::ANGLE_W-1:0] i_measured,
    input  logic                                i_measured_valid,
    output logic                                o_q_valid,
    output dclp_pkg::t_req                      o_q_req,
    input  logic                                i_q_pop
);

    localparam int QW = $clog2(dclp_pkg::Q_DEPTH);
    localparam int CW = $clog2(dclp_pkg::Q_DEPTH + 1);

    dclp_pkg::t_req r_mem [dclp_pkg::Q_DEPTH];
    logic [QW-1:0]  r_wp;
    logic [QW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    logic           in_fire;
    logic           keep;
    logic           push;
    dclp_pkg::t_req req;

    assign o_in_ready = (r_cnt != CW'(dclp_pkg::Q_DEPTH));
    assign in_fire    = i_in_valid && o_in_ready;
    // out-of-range joints are taken and dropped
    assign keep = (i_req_type == dclp_pkg::REQ_REARM) || (32'(i_joint) < JOINTS);
    assign push = in_fire && keep;

    always_comb begin
        req.rearm  = (i_req_type == dclp_pkg::REQ_REARM);
        req.joint  = i_joint;
        req.target = i_target;
        req.seed   = i_measured_valid ? i_measured : i_target;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= req;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= QW'(r_wp + 1'b1);
            end
            if (i_q_pop) begin
                r_rp <= QW'(r_rp + 1'b1);
            end
            r_cnt <= CW'(r_cnt + CW'(push) - CW'(i_q_pop));
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_req   = r_mem[r_rp];

endmodule

/* src/dclp_back.sv */
module dclp_back #(
    parameter int JOINTS = dclp_pkg::JOINTS_DEF,
    parameter int STAGES = dclp_pkg::STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dclp_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_valid,
    input  dclp_pkg::t_req                      i_q_req,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dclp_pkg::JOINT_W-1:0]        o_out_joint,
    output logic signed [dclp_pkg::ANGLE_W-1:0] o_filtered
);

    localparam int AW    = dclp_pkg::ANGLE_W;
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int SDEP  = JOINTS * STAGES;
    localparam int SW    = (SDEP > 1) ? $clog2(SDEP) : 1;
    localparam int KW    = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int PW    = AW + 1 + dclp_pkg::ALPHA_W;
    localparam int MW    = PW - 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HOLD,
        S_DIFF,
        S_STEP
    } t_state;

    t_state                         r_state;
    dclp_pkg::t_req                 r_req;
    logic                           r_fresh;
    logic [JOINTS-1:0]              r_seeded;
    logic [dclp_pkg::ALPHA_W-1:0]   r_alpha;
    logic [dclp_pkg::DB_W-1:0]      r_db;
    logic signed [AW-1:0]           r_prev;
    logic signed [AW-1:0]           r_s;
    logic [AW:0]                    r_mag;
    logic                           r_neg;
    logic [KW-1:0]                  r_k;
    logic [SW-1:0]                  r_sec_addr;
    logic                           r_out_valid;
    logic [dclp_pkg::JOINT_W-1:0]   r_out_joint;
    logic signed [AW-1:0]           r_out_filtered;

    logic [AW-1:0]                  held_rd;
    logic [AW-1:0]                  sec_rd;
    logic                           held_we;
    logic                           sec_we;
    logic [SW-1:0]                  sec_base;
    logic [SW-1:0]                  sec_raddr;

    logic signed [AW-1:0]           base;
    logic signed [AW:0]             hdiff;
    logic [AW:0]                    hadiff;
    logic signed [AW-1:0]           h;
    logic signed [AW-1:0]           s;
    logic signed [AW:0]             d;
    logic [PW-1:0]                  prod;
    logic [MW-1:0]                  m;
    logic signed [MW:0]             step;
    logic signed [MW:0]             sum;
    logic signed [AW-1:0]           snew;
    logic                           last;
    logic                           can_put;
    logic                           advance;
    logic [dclp_pkg::ALPHA_W-1:0]   a_eff;

    assign can_put  = !r_out_valid || i_out_ready;
    assign last     = (r_k == KW'(STAGES - 1));
    assign advance  = (r_state == S_STEP) && (!last || can_put);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign sec_base = SW'(i_q_req.joint * STAGES);

    always_comb begin
        if (r_state == S_IDLE) begin
            sec_raddr = sec_base;
        end else if (advance && !last) begin
            sec_raddr = SW'(r_sec_addr + 1'b1);
        end else begin
            sec_raddr = r_sec_addr;
        end
    end

    always_comb begin
        if (!i_cfg.filter_on) begin
            a_eff = dclp_pkg::ALPHA_ONE;
        end else if (i_cfg.alpha > dclp_pkg::ALPHA_ONE) begin
            a_eff = dclp_pkg::ALPHA_ONE;
        end else begin
            a_eff = i_cfg.alpha;
        end
    end

    // deadband on the held target
    always_comb begin
        base   = r_fresh ? r_req.seed : $signed(held_rd);
        hdiff  = {r_req.target[AW-1], r_req.target} - {base[AW-1], base};
        hadiff = hdiff[AW] ? (AW+1)'(-hdiff) : (AW+1)'(hdiff);
        h      = (hadiff >= (AW+1)'(r_db)) ? r_req.target : base;
    end

    // one section: d = in - s, s += round(alpha * d / 2^16)
    always_comb begin
        s    = r_fresh ? r_req.seed : $signed(sec_rd);
        d    = {r_prev[AW-1], r_prev} - {s[AW-1], s};
        prod = PW'(r_mag) * PW'(r_alpha);
        m    = MW'((prod + PW'(32768)) >> 16);
        step = r_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        sum  = {{(MW+1-AW){r_s[AW-1]}}, r_s} + step;
        if (sum > (MW+1)'(signed'(25'sd8388607))) begin
            snew = 24'sh7FFFFF;
        end else if (sum < -(MW+1)'(signed'(25'sd8388608))) begin
            snew = -24'sh800000;
        end else begin
            snew = AW'(sum);
        end
    end

    assign held_we = (r_state == S_HOLD);
    assign sec_we  = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !(advance && last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req      <= i_q_req;
                        r_fresh    <= !r_seeded[JW'(i_q_req.joint)];
                        r_alpha    <= a_eff;
                        r_db       <= i_cfg.filter_on ? i_cfg.deadband : '0;
                        r_sec_addr <= sec_base;
                        r_k        <= '0;
                        if (i_q_req.rearm) begin
                            r_seeded <= '0;
                        end else begin
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    r_prev                      <= h;
                    r_seeded[JW'(r_req.joint)] <= 1'b1;
                    r_state                     <= S_DIFF;
                end
                S_DIFF: begin
                    r_s     <= s;
                    r_neg   <= d[AW];
                    r_mag   <= d[AW] ? (AW+1)'(-d) : (AW+1)'(d);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (advance) begin
                        r_prev <= snew;
                        if (last) begin
                            r_out_valid    <= 1'b1;
                            r_out_joint    <= r_req.joint;
                            r_out_filtered <= snew;
                            r_state        <= S_IDLE;
                        end else begin
                            r_k        <= KW'(r_k + 1'b1);
                            r_sec_addr <= SW'(r_sec_addr + 1'b1);
                            r_state    <= S_DIFF;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    dclp_ram #(
        .WIDTH (AW),
        .DEPTH (JOINTS)
    ) u_held_ram (
        .i_clk   (i_clk),
        .i_we    (held_we),
        .i_waddr (JW'(r_req.joint)),
        .i_wdata (h),
        .i_raddr (JW'(i_q_req.joint)),
        .o_rdata (held_rd)
    );

    dclp_ram #(
        .WIDTH (AW),
        .DEPTH (SDEP)
    ) u_sec_ram (
        .i_clk   (i_clk),
        .i_we    (sec_we),
        .i_waddr (r_sec_addr),
        .i_wdata (snew),
        .i_raddr (sec_raddr),
        .o_rdata (sec_rd)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_joint = r_out_joint;
    assign o_filtered  = r_out_filtered;

endmodule

/* src/deadband_cascaded_lowpass_core.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_req_type i_joint i_target
//         |           |                            | i_measured i_measured_valid
// out     | output    | o_out_valid / i_out_ready  | o_out_joint o_filtered
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// A sample beat passes the back sequencer states in order: the idle state pops
// the queue and starts the RAM reads, the hold state applies the deadband,
// then a subtract and a multiply-round-add per section on the shared multiplier.
// A rearm beat is taken while idle; out-of-range joints are dropped at the front.
// A two-entry queue decouples input from the sequencer; output stall holds the
// last section until the result register frees. Synchronous active-low reset.
module deadband_cascaded_lowpass_core #(
    parameter int JOINTS = dclp_pkg::JOINTS_DEF,
    parameter int STAGES = dclp_pkg::STAGES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic [dclp_pkg::JOINT_W-1:0]           i_joint,
    input  logic signed [dclp_pkg::ANGLE_W-1:0]    i_target,
    input  logic signed [dclp_pkg::ANGLE_W-1:0]    i_measured,
    input  logic                                   i_measured_valid,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [dclp_pkg::JOINT_W-1:0]           o_out_joint,
    output logic signed [dclp_pkg::ANGLE_W-1:0]    o_filtered,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [dclp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [dclp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    dclp_pkg::t_cfg r_cfg;
    dclp_pkg::t_req q_req;
    logic           q_valid;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_on <= 1'b0;
            r_cfg.deadband  <= '0;
            r_cfg.alpha     <= dclp_pkg::ALPHA_ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dclp_pkg::CFG_FILTER_ON: r_cfg.filter_on <= i_cfg_data[0];
                dclp_pkg::CFG_DEADBAND:  r_cfg.deadband  <= i_cfg_data[dclp_pkg::DB_W-1:0];
                dclp_pkg::CFG_ALPHA:     r_cfg.alpha     <= i_cfg_data[dclp_pkg::ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dclp_front #(
        .JOINTS (JOINTS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_joint          (i_joint),
        .i_target         (i_target),
        .i_measured       (i_measured),
        .i_measured_valid (i_measured_valid),
        .o_q_valid        (q_valid),
        .o_q_req          (q_req),
        .i_q_pop          (q_pop)
    );

    dclp_back #(
        .JOINTS (JOINTS),
        .STAGES (STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_joint (o_out_joint),
        .o_filtered  (o_filtered)
    );

endmodule

/* src/dclp_checker.sv */
`include "deadband_cascaded_lowpass_core_macros.svh"

module dclp_checker #(
    parameter int JOINTS = dclp_pkg::JOINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [dclp_pkg::JOINT_W-1:0]        o_out_joint,
    input  logic signed [dclp_pkg::ANGLE_W-1:0] o_filtered
);

    `DCLP_ASSERT_RST_NXT(a_rst_empty, !i_rst_n, !o_out_valid, "result valid after reset")
    `DCLP_ASSERT_IMP(a_joint_range, o_out_valid, 32'(o_out_joint) < JOINTS, "result joint out of range")
    `DCLP_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result beat dropped")
    `DCLP_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_filtered) && $stable(o_out_joint), "result beat changed while stalled")

endmodule

bind deadband_cascaded_lowpass_core dclp_checker #(.JOINTS(JOINTS)) u_dclp_checker (.*);
